// ----- rtl/lzpad_pkg.sv -----
// Shared types and constants for the LZ phrase adjacency decoder.
// Used by lzpad_ctrl, lzpad_datapath and the top level; depends on nothing.
package lzpad_pkg;

   localparam int KIND_WIDTH      = 2;
   localparam int INDEX_WIDTH     = 16;
   localparam int OFFSET_WIDTH    = 17;
   localparam int SYMBOL_WIDTH    = 32;
   localparam int PARENT_WIDTH    = 16;
   localparam int NODE_WIDTH      = 13;
   localparam int DEGREE_WIDTH    = 7;
   localparam int REQ_DATA_WIDTH  = 96;
   localparam int RSP_DATA_WIDTH  = 40;

   localparam logic [KIND_WIDTH-1:0] KIND_LOAD_NODE   = 2'd0;
   localparam logic [KIND_WIDTH-1:0] KIND_LOAD_PHRASE = 2'd1;
   localparam logic [KIND_WIDTH-1:0] KIND_QUERY       = 2'd2;

   typedef struct packed {
      logic [KIND_WIDTH-1:0]   kind;
      logic [INDEX_WIDTH-1:0]  index;
      logic [OFFSET_WIDTH-1:0] offset_value;
      logic [SYMBOL_WIDTH-1:0] symbol;
      logic [PARENT_WIDTH-1:0] parent;
      logic [NODE_WIDTH-1:0]   node;
   } lzpad_req_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic start_query;
      logic latch_lo;
      logic walk_init;
      logic walk_step;
      logic emit_step;
      logic empty_out;
   } lzpad_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic node_bad;
      logic range_empty;
      logic walk_end;
      logic emit_done;
      logic out_free;
   } lzpad_status_type;

endpackage

// ----- rtl/lzpad_ctrl.sv -----
// Query sequencer for the LZ phrase adjacency decoder.
// Drives lzpad_datapath through lzpad_pkg command and status structs.
module lzpad_ctrl (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [lzpad_pkg::KIND_WIDTH-1:0]     req_kind,
   input  lzpad_pkg::lzpad_status_type          status,
   output lzpad_pkg::lzpad_cmd_type             cmd
);
   import lzpad_pkg::*;

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_OFF_LO = 3'd1;
   localparam logic [2:0] ST_OFF_HI = 3'd2;
   localparam logic [2:0] ST_WALK   = 3'd3;
   localparam logic [2:0] ST_EMIT   = 3'd4;
   localparam logic [2:0] ST_EMPTY  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.accept = accept;
            if (accept && req_kind == KIND_QUERY) begin
               cmd.start_query = 1'b1;
               state_in = status.node_bad ? ST_EMPTY : ST_OFF_LO;
            end
         end
         ST_OFF_LO: begin
            cmd.latch_lo = 1'b1;
            state_in     = ST_OFF_HI;
         end
         ST_OFF_HI: begin
            if (status.range_empty) begin
               state_in = ST_EMPTY;
            end else begin
               cmd.walk_init = 1'b1;
               state_in      = ST_WALK;
            end
         end
         ST_WALK: begin
            cmd.walk_step = 1'b1;
            if (status.walk_end) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            cmd.emit_step = 1'b1;
            if (status.emit_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_EMPTY: begin
            cmd.empty_out = 1'b1;
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lzpad_datapath.sv -----
// Tables, phrase walker, neighbor buffer and result register of the decoder.
// Uses lzpad_pkg; sequenced by lzpad_ctrl.
module lzpad_datapath #(
   parameter int NODES    = 4096,
   parameter int PHRASES  = 65536,
   parameter int MAX_LIST = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  lzpad_pkg::lzpad_req_type                 req,
   input  lzpad_pkg::lzpad_cmd_type                 cmd,
   output lzpad_pkg::lzpad_status_type              status,
   input  logic                                     rsp_tready,
   output logic                                     rsp_valid,
   output logic [lzpad_pkg::SYMBOL_WIDTH-1:0]       rsp_neighbor,
   output logic [lzpad_pkg::DEGREE_WIDTH-1:0]       rsp_degree,
   output logic                                     rsp_last,
   output logic                                     rsp_overflow
);
   import lzpad_pkg::*;

   localparam int NodeAddrWidth   = $clog2(NODES + 1);
   localparam int PhraseAddrWidth = $clog2(PHRASES);
   localparam int CountWidth      = $clog2(MAX_LIST + 1);
   localparam int BufAddrWidth    = (MAX_LIST > 1) ? $clog2(MAX_LIST) : 1;

   // Tables and buffer.
   logic [OFFSET_WIDTH-1:0] node_mem   [NODES + 1];
   logic [SYMBOL_WIDTH-1:0] symbol_mem [PHRASES];
   logic [PARENT_WIDTH-1:0] parent_mem [PHRASES];
   logic [SYMBOL_WIDTH-1:0] list_mem   [MAX_LIST];

   logic [OFFSET_WIDTH-1:0]  off_q;
   logic [SYMBOL_WIDTH-1:0]  sym_q;
   logic [PARENT_WIDTH-1:0]  par_q;
   logic [SYMBOL_WIDTH-1:0]  list_q;

   logic                     node_we;
   logic                     phrase_we;
   logic [NodeAddrWidth-1:0] node_ra;
   logic                     list_we;
   logic                     list_re;

   // Walk and emit registers.
   logic [NODE_WIDTH-1:0]    node_ff, node_in;
   logic [OFFSET_WIDTH-1:0]  lo_ff, lo_in;
   logic [OFFSET_WIDTH-1:0]  ph_ff, ph_in;
   logic [OFFSET_WIDTH-1:0]  pos_ff, pos_in;
   logic                     inrange_ff;
   logic [CountWidth-1:0]    cnt_ff, cnt_in;
   logic [SYMBOL_WIDTH-1:0]  remaining_ff, remaining_in;
   logic                     ovf_ff, ovf_in;
   logic [CountWidth-1:0]    rd_idx_ff, rd_idx_in;
   logic [CountWidth-1:0]    emit_idx_ff, emit_idx_in;
   logic                     q_valid_ff, q_valid_in;

   // Result register.
   logic                     out_valid_ff, out_valid_in;
   logic [SYMBOL_WIDTH-1:0]  out_neighbor_ff, out_neighbor_in;
   logic [DEGREE_WIDTH-1:0]  out_degree_ff, out_degree_in;
   logic                     out_last_ff, out_last_in;
   logic                     out_ovf_ff, out_ovf_in;

   logic [SYMBOL_WIDTH-1:0]  walk_sym;
   logic [PARENT_WIDTH-1:0]  walk_par;
   logic                     cnt_full;
   logic                     out_free;
   logic                     consume;
   logic                     last_item;
   logic                     out_load;

   assign node_we   = cmd.accept && (req.kind == KIND_LOAD_NODE) &&
                      (32'(req.index) <= 32'(NODES));
   assign phrase_we = cmd.accept && (req.kind == KIND_LOAD_PHRASE) &&
                      (32'(req.index) < 32'(PHRASES));
   assign node_ra   = cmd.start_query ? NodeAddrWidth'(req.node - NODE_WIDTH'(1))
                                      : NodeAddrWidth'(node_ff);

   // A phrase position beyond the table reads as symbol 0, parent 0.
   assign walk_sym  = inrange_ff ? sym_q : '0;
   assign walk_par  = inrange_ff ? par_q : '0;
   assign cnt_full  = (cnt_ff == CountWidth'(MAX_LIST));
   assign out_free  = !out_valid_ff || rsp_tready;
   assign consume   = cmd.emit_step && q_valid_ff && out_free;
   assign last_item = (emit_idx_ff == cnt_ff - CountWidth'(1));
   assign list_we   = cmd.walk_step && !cnt_full;
   assign list_re   = cmd.emit_step && (rd_idx_ff < cnt_ff) && (!q_valid_ff || consume);

   always_ff @(posedge clock) begin
      if (node_we) begin
         node_mem[NodeAddrWidth'(req.index)] <= req.offset_value;
      end
      off_q <= node_mem[node_ra];
   end

   always_ff @(posedge clock) begin
      if (phrase_we) begin
         symbol_mem[PhraseAddrWidth'(req.index)] <= req.symbol;
         parent_mem[PhraseAddrWidth'(req.index)] <= req.parent;
      end
      sym_q      <= symbol_mem[PhraseAddrWidth'(pos_in)];
      par_q      <= parent_mem[PhraseAddrWidth'(pos_in)];
      inrange_ff <= (32'(pos_in) < 32'(PHRASES));
   end

   always_ff @(posedge clock) begin
      if (list_we) begin
         list_mem[BufAddrWidth'(cnt_ff)] <= walk_sym;
      end
      if (list_re) begin
         list_q <= list_mem[BufAddrWidth'(rd_idx_ff)];
      end
   end

   always_comb begin
      node_in         = node_ff;
      lo_in           = lo_ff;
      ph_in           = ph_ff;
      pos_in          = pos_ff;
      cnt_in          = cnt_ff;
      remaining_in    = remaining_ff;
      ovf_in          = ovf_ff;
      rd_idx_in       = rd_idx_ff;
      emit_idx_in     = emit_idx_ff;
      q_valid_in      = q_valid_ff;
      out_neighbor_in = out_neighbor_ff;
      out_degree_in   = out_degree_ff;
      out_last_in     = out_last_ff;
      out_ovf_in      = out_ovf_ff;
      out_load        = 1'b0;

      if (cmd.start_query) begin
         node_in = req.node;
      end
      if (cmd.latch_lo) begin
         lo_in = off_q;
      end
      if (cmd.walk_init) begin
         ph_in        = off_q - OFFSET_WIDTH'(1);
         pos_in       = off_q - OFFSET_WIDTH'(1);
         cnt_in       = '0;
         remaining_in = '0;
         ovf_in       = 1'b0;
         rd_idx_in    = '0;
         emit_idx_in  = '0;
         q_valid_in   = 1'b0;
      end
      // One phrase per cycle: the next read address comes straight from the
      // parent just read, or from the next lower phrase of the node.
      if (cmd.walk_step) begin
         if (cnt_full) begin
            ovf_in = 1'b1;
         end else begin
            remaining_in = remaining_ff + walk_sym;
            cnt_in       = cnt_ff + CountWidth'(1);
            if (walk_par != '0) begin
               pos_in = {1'b0, walk_par};
            end else if (ph_ff > lo_ff) begin
               ph_in  = ph_ff - OFFSET_WIDTH'(1);
               pos_in = ph_ff - OFFSET_WIDTH'(1);
            end
         end
      end
      // The running total starts as the sum of all gaps; each beat peels off
      // its own gap, which yields the suffix sums in collection order.
      if (cmd.emit_step) begin
         if (list_re) begin
            rd_idx_in = rd_idx_ff + CountWidth'(1);
         end
         q_valid_in = list_re || (q_valid_ff && !consume);
         if (consume) begin
            out_load        = 1'b1;
            out_neighbor_in = remaining_ff;
            out_degree_in   = DEGREE_WIDTH'(cnt_ff);
            out_last_in     = last_item;
            out_ovf_in      = ovf_ff;
            remaining_in    = remaining_ff - list_q;
            emit_idx_in     = emit_idx_ff + CountWidth'(1);
         end
      end
      if (cmd.empty_out && out_free) begin
         out_load        = 1'b1;
         out_neighbor_in = '0;
         out_degree_in   = '0;
         out_last_in     = 1'b1;
         out_ovf_in      = 1'b0;
      end

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         q_valid_ff   <= q_valid_in;
         out_valid_ff <= out_valid_in;
      end
      node_ff         <= node_in;
      lo_ff           <= lo_in;
      ph_ff           <= ph_in;
      pos_ff          <= pos_in;
      cnt_ff          <= cnt_in;
      remaining_ff    <= remaining_in;
      ovf_ff          <= ovf_in;
      rd_idx_ff       <= rd_idx_in;
      emit_idx_ff     <= emit_idx_in;
      out_neighbor_ff <= out_neighbor_in;
      out_degree_ff   <= out_degree_in;
      out_last_ff     <= out_last_in;
      out_ovf_ff      <= out_ovf_in;
   end

   assign status.node_bad    = (req.node == '0) || (32'(req.node) > 32'(NODES));
   assign status.range_empty = (lo_ff >= off_q);
   assign status.walk_end    = cnt_full || ((walk_par == '0) && (ph_ff <= lo_ff));
   assign status.emit_done   = consume && last_item;
   assign status.out_free    = out_free;

   assign rsp_valid    = out_valid_ff;
   assign rsp_neighbor = out_neighbor_ff;
   assign rsp_degree   = out_degree_ff;
   assign rsp_last     = out_last_ff;
   assign rsp_overflow = out_ovf_ff;

endmodule

// ----- rtl/lz_phrase_adjacency_decoder.sv -----
// Top level of the LZ phrase adjacency decoder: stream ports and wiring.
// Instantiates lzpad_ctrl and lzpad_datapath; uses lzpad_pkg.
//
// Load beats (kind 0 node offset, kind 1 phrase symbol and parent) are taken
// while idle and produce no result; kind 3 is taken and ignored.
// A query (kind 2) returns one beat per neighbor with degree, tlast on the
// final beat and tuser set on every beat when the walk was cut at MAX_LIST.
// An empty or out-of-range node returns a single beat with degree 0. A query
// makes two offset reads, then one phrase-table read per collected symbol on
// the single read port, then one result beat per cycle out of the neighbor
// buffer while tready is high. No new item is taken until the last beat of a
// query is registered.
// All tables come up undefined and must be loaded before they are queried.
module lz_phrase_adjacency_decoder #(
   parameter int NODES    = 4096,
   parameter int PHRASES  = 65536,
   parameter int MAX_LIST = 64
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   // index[15:0], offset_value[32:16], symbol[64:33], parent[80:65],
   // node[93:81], zero pad[95:94]
   input  logic [lzpad_pkg::REQ_DATA_WIDTH-1:0]     req_tdata,
   // kind[1:0]
   input  logic [lzpad_pkg::KIND_WIDTH-1:0]         req_tuser,
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   // neighbor[31:0], degree[38:32], zero pad[39]
   output logic [lzpad_pkg::RSP_DATA_WIDTH-1:0]     rsp_tdata,
   output logic                                     rsp_tlast,
   // overflow[0]
   output logic [0:0]                               rsp_tuser
);
   import lzpad_pkg::*;

   lzpad_req_type              req;
   lzpad_cmd_type              cmd;
   lzpad_status_type           status;
   logic [SYMBOL_WIDTH-1:0]    rsp_neighbor;
   logic [DEGREE_WIDTH-1:0]    rsp_degree;
   logic                       rsp_overflow;

   assign req.kind         = req_tuser;
   assign req.index        = req_tdata[15:0];
   assign req.offset_value = req_tdata[32:16];
   assign req.symbol       = req_tdata[64:33];
   assign req.parent       = req_tdata[80:65];
   assign req.node         = req_tdata[93:81];

   lzpad_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_kind   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   lzpad_datapath #(
      .NODES    (NODES),
      .PHRASES  (PHRASES),
      .MAX_LIST (MAX_LIST)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req          (req),
      .cmd          (cmd),
      .status       (status),
      .rsp_tready   (rsp_tready),
      .rsp_valid    (rsp_tvalid),
      .rsp_neighbor (rsp_neighbor),
      .rsp_degree   (rsp_degree),
      .rsp_last     (rsp_tlast),
      .rsp_overflow (rsp_overflow)
   );

   assign rsp_tdata = {1'b0, rsp_degree, rsp_neighbor};
   assign rsp_tuser = rsp_overflow;

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps
// Testbench for lz_phrase_adjacency_decoder: fills the offset and phrase tables, queries
// nodes and checks every neighbor beat against an in-bench decoder of the phrase store.
// Depends on lzpad_pkg and the decoder RTL only.
module tb;
   import lzpad_pkg::*;

   localparam int NODE_COUNT   = 4096;
   localparam int PHRASE_COUNT = 65536;
   localparam int LIST_LIMIT   = 64;
   localparam int CYCLE_LIMIT  = 3_000_000;
   localparam int TAIL_CYCLES  = 200;
   localparam int ITEM_TARGET  = 460;
   localparam int NODE_FIELD_MAX = 8191;
   localparam logic [KIND_WIDTH-1:0] KIND_IGNORED = 2'd3;

   typedef struct packed {
      logic [31:0] neighbor;
      logic [6:0]  degree;
      logic        last;
      logic        overflow;
   } neighbor_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_WIDTH-1:0] req_tdata = '0;
   logic [KIND_WIDTH-1:0]     req_tuser = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0] rsp_tdata;
   logic                      rsp_tlast;
   logic [0:0]                rsp_tuser;

   lz_phrase_adjacency_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Decoder copy of the phrase store, updated on every accepted request beat.
   logic [16:0] node_first_phrase [0:NODE_COUNT];
   logic [31:0] phrase_gap [0:PHRASE_COUNT-1];
   logic [15:0] phrase_link [0:PHRASE_COUNT-1];
   neighbor_beat_type expected_neighbors[$];

   // Stimulus plan: what has been loaded so far, so that no query reads an unloaded entry.
   int plan_offset [0:NODE_COUNT];
   bit plan_offset_known [0:NODE_COUNT];
   bit plan_phrase_known [0:PHRASE_COUNT-1];
   int known_phrases[$];
   int built_nodes[$];
   lzpad_req_type pending_items[$];
   bit pending_drain[$];
   int stim_items = 0;

   int mismatches = 0;
   int beats_seen = 0;
   int cycles = 0;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch at result beat %0d: %s is 0x%0h, expected 0x%0h",
               beats_seen, what, got, want);
   endtask

   task automatic decode_item(input lzpad_req_type it);
      int lo, hi, ph, pos, cnt, link;
      logic [31:0] gaps [0:LIST_LIMIT-1];
      logic ovf, done;
      neighbor_beat_type beat;
      lo = 0;
      hi = 0;
      cnt = 0;
      ovf = 1'b0;
      case (it.kind)
         KIND_LOAD_NODE: begin
            if (it.index <= NODE_COUNT)
               node_first_phrase[it.index] = it.offset_value;
         end
         KIND_LOAD_PHRASE: begin
            phrase_gap[it.index]  = it.symbol;
            phrase_link[it.index] = it.parent;
         end
         KIND_QUERY: begin
            if (it.node != 0 && it.node <= NODE_COUNT) begin
               lo = node_first_phrase[it.node - 1];
               hi = node_first_phrase[it.node];
            end
            if (lo < hi) begin
               ph = hi - 1;
               pos = ph;
               done = 1'b0;
               while (!done) begin
                  if (cnt >= LIST_LIMIT) begin
                     ovf = 1'b1;
                     done = 1'b1;
                  end else begin
                     // Positions past the phrase table read as an empty, unlinked phrase.
                     if (pos < PHRASE_COUNT) begin
                        gaps[cnt] = phrase_gap[pos];
                        link = phrase_link[pos];
                     end else begin
                        gaps[cnt] = '0;
                        link = 0;
                     end
                     cnt++;
                     if (link != 0) begin
                        pos = link;
                     end else if (ph <= lo) begin
                        done = 1'b1;
                     end else begin
                        ph--;
                        pos = ph;
                     end
                  end
               end
               for (int k = cnt - 1; k >= 1; k--)
                  gaps[k-1] = gaps[k-1] + gaps[k];
            end
            if (cnt == 0) begin
               beat.neighbor = '0;
               beat.degree = '0;
               beat.last = 1'b1;
               beat.overflow = 1'b0;
               expected_neighbors.push_back(beat);
            end else begin
               for (int k = 0; k < cnt; k++) begin
                  beat.neighbor = gaps[k];
                  beat.degree = 7'(cnt);
                  beat.last = (k == cnt - 1);
                  beat.overflow = ovf;
                  expected_neighbors.push_back(beat);
               end
            end
         end
         default: ;
      endcase
   endtask

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // Fields that the beat's kind does not use still carry random bits.
   function automatic lzpad_req_type scrambled_item(logic [KIND_WIDTH-1:0] kind);
      lzpad_req_type it;
      it.kind = kind;
      it.index = 16'($urandom);
      it.offset_value = 17'($urandom);
      it.symbol = $urandom;
      it.parent = 16'($urandom);
      it.node = 13'($urandom);
      return it;
   endfunction

   function automatic void queue_item(lzpad_req_type it, bit drain, bit counted);
      pending_items.push_back(it);
      pending_drain.push_back(drain);
      if (counted)
         stim_items++;
   endfunction

   function automatic void load_offset(int idx, int value);
      lzpad_req_type it = scrambled_item(KIND_LOAD_NODE);
      it.index = 16'(idx);
      it.offset_value = 17'(value);
      if (idx <= NODE_COUNT) begin
         plan_offset[idx] = value;
         plan_offset_known[idx] = 1'b1;
      end
      queue_item(it, 1'b0, idx <= NODE_COUNT);
   endfunction

   function automatic void load_phrase(int idx, logic [31:0] gap, int link);
      lzpad_req_type it = scrambled_item(KIND_LOAD_PHRASE);
      // A link may only name a loaded phrase or the phrase itself, so every chain
      // that starts at a loaded phrase stays on loaded phrases.
      if (link != 0 && link != idx && !plan_phrase_known[link])
         link = 0;
      it.index = 16'(idx);
      it.symbol = gap;
      it.parent = 16'(link);
      if (!plan_phrase_known[idx])
         known_phrases.push_back(idx);
      plan_phrase_known[idx] = 1'b1;
      queue_item(it, 1'b0, 1'b1);
   endfunction

   function automatic bit query_is_safe(int node);
      int lo, hi;
      if (node == 0 || node > NODE_COUNT)
         return 1'b1;
      if (!plan_offset_known[node-1] || !plan_offset_known[node])
         return 1'b0;
      lo = plan_offset[node-1];
      hi = plan_offset[node];
      // The walk steps through at most LIST_LIMIT positions at the top of the range.
      for (int p = (hi - LIST_LIMIT > lo) ? hi - LIST_LIMIT : lo; p < hi; p++)
         if (p < PHRASE_COUNT && !plan_phrase_known[p])
            return 1'b0;
      return 1'b1;
   endfunction

   function automatic void ask(int node, bit drain);
      lzpad_req_type it = scrambled_item(KIND_QUERY);
      it.node = 13'(node);
      if (query_is_safe(node))
         queue_item(it, drain, 1'b1);
   endfunction

   function automatic void queue_noise();
      lzpad_req_type it;
      if ($urandom_range(0, 1)) begin
         it = scrambled_item(KIND_IGNORED);
      end else begin
         it = scrambled_item(KIND_LOAD_NODE);
         it.index = 16'($urandom_range(NODE_COUNT + 1, 65535));
      end
      queue_item(it, 1'b0, 1'b0);
   endfunction

   function automatic logic [31:0] pick_gap_value();
      case ($urandom_range(0, 9))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         2: return $urandom_range(1, 15);
         default: return $urandom;
      endcase
   endfunction

   function automatic int pick_link(int p);
      int r;
      r = $urandom_range(0, 99);
      if (r < 70 || known_phrases.size() == 0)
         return 0;
      if (r < 90)
         return known_phrases[$urandom_range(0, known_phrases.size() - 1)];
      if (r < 98)
         return (p > 0) ? p - 1 : 0;
      return p;
   endfunction

   // One node built from scratch: both offsets, the phrases the walk can reach, a query.
   function automatic void build_node();
      int node, span, lo, hi, first, r;
      r = $urandom_range(0, 19);
      node = (r == 0) ? 1 : (r == 1) ? NODE_COUNT : $urandom_range(1, NODE_COUNT);
      r = $urandom_range(0, 99);
      span = (r < 8)  ? 0 :
             (r < 80) ? $urandom_range(1, 6) :
             (r < 93) ? $urandom_range(7, 20) : $urandom_range(60, 70);
      if ($urandom_range(0, 29) == 0)
         lo = $urandom_range(PHRASE_COUNT - 8, PHRASE_COUNT);
      else
         lo = $urandom_range(0, PHRASE_COUNT - span);
      hi = lo + span;
      if ($urandom_range(0, 1)) begin
         load_offset(node - 1, lo);
         load_offset(node, hi);
      end else begin
         load_offset(node, hi);
         load_offset(node - 1, lo);
      end
      first = (hi - LIST_LIMIT > lo) ? hi - LIST_LIMIT : lo;
      for (int p = first; p < hi && p < PHRASE_COUNT; p++)
         load_phrase(p, pick_gap_value(), pick_link(p));
      ask(node, $urandom_range(0, 24) == 0);
      built_nodes.push_back(node);
   endfunction

   initial begin : stimulus
      int r, node, lo, p;

      // Chained phrases down to phrase 0 with a gap sum that wraps.
      load_offset(0, 0);
      load_offset(1, 3);
      load_phrase(0, 32'hFFFF_FFFF, 0);
      load_phrase(1, 32'd5, 0);
      load_phrase(2, 32'd1, 1);
      ask(1, 1'b0);
      // Empty range, inverted range, nodes outside the table.
      load_offset(2, 3);
      ask(2, 1'b0);
      load_offset(3, 1);
      ask(3, 1'b0);
      ask(0, 1'b0);
      ask(NODE_FIELD_MAX, 1'b0);
      // A range that runs past the end of the phrase table.
      load_phrase(65534, 32'd7, 0);
      load_phrase(65535, 32'h8000_0000, 0);
      load_offset(9, 65534);
      load_offset(10, 65540);
      ask(10, 1'b0);
      // Last node, top offset, and a phrase linked to itself that overruns the list.
      load_offset(NODE_COUNT - 1, 65535);
      load_offset(NODE_COUNT, 65536);
      load_phrase(65535, 32'h8000_0000, 65535);
      ask(NODE_COUNT, 1'b1);
      // Beats that the block takes and drops.
      queue_noise();
      load_offset(65535, 0);
      load_offset(NODE_COUNT + 1, 0);

      while (stim_items < ITEM_TARGET) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            build_node();
         end else if (r < 68 && built_nodes.size() > 0) begin
            ask(built_nodes[$urandom_range(0, built_nodes.size() - 1)], 1'b0);
         end else if (r < 76) begin
            if ($urandom_range(0, 1)) begin
               ask($urandom_range(0, 1) ? 0 : $urandom_range(NODE_COUNT + 1, NODE_FIELD_MAX),
                   1'b0);
            end else begin
               node = $urandom_range(1, NODE_COUNT);
               lo = $urandom_range(0, PHRASE_COUNT);
               load_offset(node - 1, lo);
               load_offset(node, lo - $urandom_range(0, (lo < 5) ? lo : 5));
               ask(node, 1'b0);
            end
         end else if (r < 86 && known_phrases.size() > 0) begin
            p = known_phrases[$urandom_range(0, known_phrases.size() - 1)];
            load_phrase(p, pick_gap_value(), pick_link(p));
         end else if (r < 92) begin
            load_offset($urandom_range(0, NODE_COUNT), $urandom_range(0, PHRASE_COUNT));
         end else begin
            queue_noise();
         end
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || req_tvalid || expected_neighbors.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && expected_neighbors.size() == 0)
         $display("** lz_phrase_adjacency_decoder: PASSED **");
      else
         $display("** lz_phrase_adjacency_decoder: FAILED **");
      $finish;
   end

   // Request side: one beat per pending item, with random gaps between beats.
   int req_gap = 0;
   int req_calm = 0;

   always @(posedge clock) begin : request_driver
      lzpad_req_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
         req_gap <= 0;
         req_calm <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_tvalid <= 1'b0;
         end else if (pending_items.size() != 0 &&
                      !(pending_drain[0] && (req_tvalid || expected_neighbors.size() != 0))) begin
            next_item = pending_items.pop_front();
            void'(pending_drain.pop_front());
            req_tvalid <= 1'b1;
            req_tdata <= {2'b00, next_item.node, next_item.parent, next_item.symbol,
                          next_item.offset_value, next_item.index};
            req_tuser <= next_item.kind;
            if (req_calm > 0) begin
               req_calm <= req_calm - 1;
               req_gap <= 0;
            end else begin
               req_gap <= gap_len();
               if ($urandom_range(0, 31) == 0)
                  req_calm <= $urandom_range(16, 48);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result side: tready drops for random stretches, now and then not at all.
   int rsp_stall = 0;
   int rsp_calm = 0;

   always @(posedge clock) begin : result_sink
      int pause;
      if (reset) begin
         rsp_tready <= 1'b0;
         rsp_stall <= 0;
         rsp_calm <= 0;
      end else if (rsp_stall > 0) begin
         rsp_stall <= rsp_stall - 1;
         rsp_tready <= 1'b0;
      end else if (rsp_calm > 0) begin
         rsp_calm <= rsp_calm - 1;
         rsp_tready <= 1'b1;
      end else if ((rsp_tvalid && rsp_tready) || $urandom_range(0, 7) == 0) begin
         pause = gap_len();
         rsp_tready <= (pause == 0);
         rsp_stall <= (pause > 0) ? pause - 1 : 0;
         if ($urandom_range(0, 31) == 0)
            rsp_calm <= $urandom_range(16, 64);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Checks each result beat, then feeds each accepted request beat to the decoder.
   always @(posedge clock) begin : beat_monitor
      lzpad_req_type seen;
      neighbor_beat_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            if (expected_neighbors.size() == 0) begin
               report_mismatch("neighbor with nothing expected", rsp_tdata[31:0], 32'd0);
            end else begin
               want = expected_neighbors.pop_front();
               if (rsp_tdata[31:0] !== want.neighbor)
                  report_mismatch("neighbor", rsp_tdata[31:0], want.neighbor);
               if (rsp_tdata[38:32] !== want.degree)
                  report_mismatch("degree", rsp_tdata[38:32], want.degree);
               if (rsp_tlast !== want.last)
                  report_mismatch("last flag", rsp_tlast, want.last);
               if (rsp_tuser[0] !== want.overflow)
                  report_mismatch("overflow flag", rsp_tuser[0], want.overflow);
            end
         end
         if (req_tvalid && req_tready) begin
            seen.kind = req_tuser;
            seen.index = req_tdata[15:0];
            seen.offset_value = req_tdata[32:16];
            seen.symbol = req_tdata[64:33];
            seen.parent = req_tdata[80:65];
            seen.node = req_tdata[93:81];
            decode_item(seen);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("** lz_phrase_adjacency_decoder: FAILED **");
         $finish;
      end
   end

endmodule
